// ===== hw/rtl/chh_pkg.sv =====
package chh_pkg;

  // Store geometry.
  localparam int unsigned PACKETS    = 8;
  localparam int unsigned MODULES    = 14;
  localparam int unsigned CHIPS      = 26;
  localparam int unsigned CHANNELS   = 128;
  localparam int unsigned COUNT_BITS = 32;

  localparam int unsigned DEPTH = PACKETS * MODULES * CHIPS * CHANNELS;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam int unsigned PACKET_BASE = 3001;
  localparam int unsigned CHIP_FOLD   = 26;
  localparam logic [6:0]  CROSS_MASK  = 7'h7f;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [31:0]           CLONE_MAX = 32'hffff_ffff;

  // Depth of the queue between the classifier and the counter engine.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_HIT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       event_start;
    logic [11:0] packet;
    logic [3:0] module_req;
    logic [5:0] chip_raw;
    logic [6:0] channel;
    logic [6:0] crossing_full_low;
    logic [6:0] crossing_hit;
  } in_t;

  typedef struct packed {
    logic [6:0]  crossing_diff;
    logic        is_clone;
    logic        bad_address;
    logic [31:0] count;
    logic [31:0] clone_total;
  } out_t;

  // One classified beat waiting for the counter engine.
  typedef struct packed {
    cmd_e             cmd;
    logic             ok;
    logic             clone;
    logic [IDX_W-1:0] idx;
    logic [6:0]       crossing_diff;
    logic [31:0]      clone_total;
  } job_t;

endpackage

// ===== hw/rtl/chh_front.sv =====
module chh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  chh_pkg::in_t  in_i,
  input  logic          queue_full_i,
  input  logic          init_done_i,
  output logic          push_o,
  output chh_pkg::job_t job_o
);
  import chh_pkg::*;

  logic             prev_valid_q, prev_valid_d;
  logic [IDX_W-1:0] prev_addr_q, prev_addr_d;
  logic [31:0]      clone_total_q, clone_total_d;

  logic [11:0]      pkt_idx;
  logic [5:0]       chip_f;
  logic             ok;
  logic [31:0]      idx_wide;
  logic [IDX_W-1:0] idx;
  logic             prev_eff;
  logic             clone;
  logic [6:0]       diff;
  logic             is_hit;

  assign in_ready_o = init_done_i && !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;
  assign is_hit     = (in_i.cmd == CMD_HIT);

  always_comb begin
    chip_f  = (32'(in_i.chip_raw) > CHIP_FOLD) ? in_i.chip_raw - 6'(CHIP_FOLD) : in_i.chip_raw;
    pkt_idx = in_i.packet - 12'(PACKET_BASE);
    ok = (32'(in_i.packet) >= PACKET_BASE) && (32'(pkt_idx) < PACKETS) &&
         (32'(in_i.module_req) < MODULES) && (chip_f != 6'd0) &&
         (32'(chip_f) <= CHIPS) && (32'(in_i.channel) < CHANNELS);
    idx_wide = ((32'(pkt_idx) * MODULES + 32'(in_i.module_req)) * CHIPS +
                (32'(chip_f) - 32'd1)) * CHANNELS + 32'(in_i.channel);
    idx = ok ? idx_wide[IDX_W-1:0] : '0;

    prev_eff = prev_valid_q && !in_i.event_start;
    clone    = is_hit && ok && prev_eff && (prev_addr_q == idx);

    if (in_i.crossing_full_low >= in_i.crossing_hit) begin
      diff = (in_i.crossing_full_low - in_i.crossing_hit) & CROSS_MASK;
    end else begin
      diff = (in_i.crossing_hit - in_i.crossing_full_low) & CROSS_MASK;
    end
    if (!is_hit) begin
      diff = '0;
    end

    prev_valid_d  = prev_valid_q;
    prev_addr_d   = prev_addr_q;
    clone_total_d = clone_total_q;
    if (push_o && is_hit) begin
      prev_valid_d = ok ? 1'b1 : prev_eff;
      if (ok) begin
        prev_addr_d = idx;
      end
      if (clone && (clone_total_q != CLONE_MAX)) begin
        clone_total_d = clone_total_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q  <= 1'b0;
      prev_addr_q   <= '0;
      clone_total_q <= '0;
    end else begin
      prev_valid_q  <= prev_valid_d;
      prev_addr_q   <= prev_addr_d;
      clone_total_q <= clone_total_d;
    end
  end

  always_comb begin
    job_o.cmd           = in_i.cmd;
    job_o.ok            = ok;
    job_o.clone         = clone;
    job_o.idx           = idx;
    job_o.crossing_diff = diff;
    job_o.clone_total   = clone_total_d;
  end

endmodule

// ===== hw/rtl/chh_queue.sv =====
module chh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  chh_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output chh_pkg::job_t head_o
);
  import chh_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (32'(cnt_q) == QUEUE_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/chh_back.sv =====
module chh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  chh_pkg::job_t job_i,
  output logic          pop_o,
  output logic          init_done_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output chh_pkg::out_t out_o
);
  import chh_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e                state_q;
  logic [IDX_W-1:0]      clr_idx_q;
  job_t                  job_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q;

  logic [COUNT_BITS-1:0] counters [DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;

  logic                  can_load;
  logic                  bump;
  logic [COUNT_BITS-1:0] new_count;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  out_t                  result;

  assign pop_o       = (state_q == ST_IDLE) && job_valid_i;
  assign can_load    = !out_valid_q || out_ready_i;
  assign init_done_o = (state_q != ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    bump      = (job_q.cmd == CMD_HIT) && job_q.ok && !job_q.clone &&
                (rdata_q != COUNT_MAX);
    new_count = bump ? rdata_q + COUNT_BITS'(1) : rdata_q;

    result.crossing_diff = job_q.crossing_diff;
    result.is_clone      = job_q.clone;
    result.bad_address   = !job_q.ok;
    result.count         = job_q.ok ? 32'(new_count) : 32'd0;
    result.clone_total   = job_q.clone_total;

    mem_we    = 1'b0;
    mem_waddr = job_q.idx;
    mem_wdata = new_count;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else if ((state_q == ST_UPDATE) && can_load && bump) begin
      mem_we = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_UPDATE) && can_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + IDX_W'(1);
          if (32'(clr_idx_q) == DEPTH - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (job_valid_i) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (can_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers of the job in flight and the result beat.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if ((state_q == ST_UPDATE) && can_load) begin
      out_q <= result;
    end
  end

  // Counter store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      counters[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rdata_q <= counters[job_i.idx];
    end
  end

endmodule

// ===== hw/rtl/channel_hit_histogram_with_clone_reject.sv =====
// Per-channel hit histogram with clone rejection. Each input beat either
// records a raw hit (packet, module, raw chip, channel) or reads back one
// channel counter; every beat returns exactly one result beat, in order.
// Raw chips above 26 fold down by 26, and a hit that repeats the previous
// valid hit's address inside the same event counts as a clone instead of
// bumping its channel counter. A front classifier decodes the address,
// makes the clone decision and keeps the clone total, taking one beat per
// cycle into a two-entry queue while the queue has room. The counter engine
// behind it reads the counter store when it takes a job and writes any
// updated count back once its result register can load; it takes no new
// job before that read-modify-write is done. A stalled output register holds
// one result while the queue keeps taking beats. After reset the engine zeroes
// all 372736 counters, one per cycle, and in_ready_o stays low until that is done.
module channel_hit_histogram_with_clone_reject (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  chh_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output chh_pkg::out_t out_o
);
  import chh_pkg::*;

  logic push;
  logic queue_full;
  logic init_done;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  // The classifier owns the previous-hit compare and the clone total, since
  // both follow from the beat sequence alone and need no counter value.
  chh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .init_done_i  (init_done),
    .push_o       (push),
    .job_o        (push_job)
  );

  chh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head_job)
  );

  // The engine handles one job at a time, so its write always lands before
  // the next read of the store and no forwarding path is needed.
  chh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/chh_checker.sv =====
module chh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input chh_pkg::in_t  in_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input chh_pkg::out_t out_o
);
  import chh_pkg::*;

  // A waiting input beat stays on the bus unchanged until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_i))
    else $error("input beat dropped or changed while waiting");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result beat changed while stalled");

  // A rejected address never reports a count or a clone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.bad_address |-> out_o.count == 32'd0 && !out_o.is_clone)
    else $error("bad address with nonzero count or clone flag");

  // A clone has already been added to the clone total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.is_clone |-> out_o.clone_total != 32'd0)
    else $error("clone reported with zero clone total");

  // A recorded, non-clone hit leaves its counter at one or more.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.bad_address && !out_o.is_clone && out_o.crossing_diff != 7'd0
      |-> out_o.count != 32'd0)
    else $error("recorded hit returned a zero counter");

endmodule

bind channel_hit_histogram_with_clone_reject chh_checker u_chh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
